[rtl/core/amix_pkg.sv]
`timescale 1ns / 1ps
package amix_pkg;

  localparam int MAX_CLIENTS = 4;
  localparam int SUM_W       = 19;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_CLEAR = 2'd1,
    FN_TICK  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SUM,
    S_OUT
  } state_t;

  // scale by 65536 and saturate to signed 32 bits
  function automatic logic [31:0] clamp_mix(logic signed [SUM_W-1:0] s);
    logic in_range;
    in_range = (s[SUM_W-1:15] == '0) || (s[SUM_W-1:15] == '1);
    if (in_range) begin
      return {s[15:0], 16'h0000};
    end else if (s[SUM_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

endpackage

[rtl/core/amix_ram.sv]
`timescale 1ns / 1ps
module amix_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/multi_client_audio_fifo_mixer_top.sv]
`timescale 1ns / 1ps
// Push, clear and unused items: result in the output register next cycle.
// Tick items: one client per cycle through the single read port of the frame memory,
// NUM_CLIENTS (at most 4) in all, then S_SUM and S_OUT; one item at a time.
// Reset (rst_n, synchronous, active low) clears pointers, fill counts, flags, period
// position, mute latch, counters and the attach mask; the frame memory is not cleared.
module multi_client_audio_fifo_mixer_top #(
  parameter int NUM_CLIENTS   = 4,
  parameter int QUEUE_FRAMES  = 256,
  parameter int PERIOD_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_client,
  input  logic [15:0] in_left_in,
  input  logic [15:0] in_right_in,
  input  logic        in_audible,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [31:0] out_mix_left,
  output logic [31:0] out_mix_right,
  output logic        out_period_end,
  output logic [8:0]  out_queued_frames,
  output logic [31:0] out_canceled_total,
  output logic [31:0] out_underrun_total,
  output logic [31:0] out_starved_total,
  output logic [31:0] out_full_refusals
);
  import amix_pkg::*;

  localparam int NCE   = (NUM_CLIENTS < MAX_CLIENTS) ? NUM_CLIENTS : MAX_CLIENTS;
  localparam int CW    = (NCE > 1) ? $clog2(NCE) : 1;
  localparam int PW    = $clog2(QUEUE_FRAMES);
  localparam int FW    = $clog2(QUEUE_FRAMES + 1);
  localparam int DEPTH = NCE * QUEUE_FRAMES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PPW   = (PERIOD_FRAMES > 1) ? $clog2(PERIOD_FRAMES) : 1;

  state_t state_r, state_nxt;
  logic [PW-1:0] rp_r [NCE];
  logic [PW-1:0] rp_nxt [NCE];
  logic [FW-1:0] fill_r [NCE];
  logic [FW-1:0] fill_nxt [NCE];
  logic [NCE-1:0] started_r, started_nxt, uflag_r, uflag_nxt, missed_r, missed_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic [PPW-1:0] pos_r, pos_nxt;
  logic aud_r, aud_nxt;
  logic [31:0] cancel_r, cancel_nxt, under_r, under_nxt, starve_r, starve_nxt;
  logic [31:0] refuse_r, refuse_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] cl_r, cl_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic signed [SUM_W-1:0] suml_r, suml_nxt, sumr_r, sumr_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_acc_r, out_acc_nxt, out_pend_r, out_pend_nxt;
  logic [31:0] out_ml_r, out_ml_nxt, out_mr_r, out_mr_nxt;
  logic [8:0] out_q_r, out_q_nxt;

  logic [3:0] att_vec;
  logic in_fire, cfg_fire, out_free, pend;
  logic [CW-1:0] in_idx, cl_idx;
  logic [FW:0] slot_w;
  logic [2:0] uinc;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_q;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_idx    = in_client[CW-1:0];
  assign cl_idx    = cl_r[CW-1:0];
  assign pend      = (pos_r == PPW'(PERIOD_FRAMES - 1));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      att_vec[i] = (i < NCE) && mask_r[i];
    end
  end

  amix_ram #(.DEPTH(DEPTH), .AW(AW), .DW(32)) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_right_in, in_left_in}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    state_nxt   = state_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    started_nxt = started_r;
    uflag_nxt   = uflag_r;
    missed_nxt  = missed_r;
    mask_nxt    = mask_r;
    pos_nxt     = pos_r;
    aud_nxt     = aud_r;
    cancel_nxt  = cancel_r;
    under_nxt   = under_r;
    starve_nxt  = starve_r;
    refuse_nxt  = refuse_r;
    cnt_nxt     = cnt_r;
    cl_nxt      = cl_r;
    rd_pend_nxt = 1'b0;
    suml_nxt    = suml_r;
    sumr_nxt    = sumr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_pend_nxt  = out_pend_r;
    out_ml_nxt    = out_ml_r;
    out_mr_nxt    = out_mr_r;
    out_q_nxt     = out_q_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    slot_w    = '0;
    uinc      = '0;

    if (rd_pend_r) begin
      suml_nxt = suml_r + {{(SUM_W-16){ram_q[15]}}, ram_q[15:0]};
      sumr_nxt = sumr_r + {{(SUM_W-16){ram_q[31]}}, ram_q[31:16]};
    end

    if (cfg_fire) begin
      mask_nxt = cfg_data;
      // drop the slot of every client that detaches
      for (int c = 0; c < NCE; c++) begin
        if (mask_r[c] && !cfg_data[c]) begin
          rp_nxt[c]      = '0;
          fill_nxt[c]    = '0;
          started_nxt[c] = 1'b0;
          uflag_nxt[c]   = 1'b0;
          missed_nxt[c]  = 1'b0;
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_acc_nxt  = 1'b0;
          out_pend_nxt = 1'b0;
          out_ml_nxt   = '0;
          out_mr_nxt   = '0;
          unique case (in_func)
            FN_PUSH: begin
              if (att_vec[in_client]) begin
                if (fill_r[in_idx] < FW'(QUEUE_FRAMES)) begin
                  slot_w = (FW+1)'(rp_r[in_idx]) + (FW+1)'(fill_r[in_idx]);
                  if (slot_w >= (FW+1)'(QUEUE_FRAMES)) begin
                    slot_w = slot_w - (FW+1)'(QUEUE_FRAMES);
                  end
                  ram_we    = 1'b1;
                  ram_waddr = AW'(in_idx) * AW'(QUEUE_FRAMES) + AW'(slot_w);
                  fill_nxt[in_idx]    = fill_r[in_idx] + 1'b1;
                  started_nxt[in_idx] = 1'b1;
                  out_acc_nxt         = 1'b1;
                end else begin
                  refuse_nxt = refuse_r + 32'd1;
                end
              end
            end
            FN_CLEAR: begin
              if (att_vec[in_client]) begin
                cancel_nxt          = cancel_r + 32'(fill_r[in_idx]);
                fill_nxt[in_idx]    = '0;
                started_nxt[in_idx] = 1'b0;
                uflag_nxt[in_idx]   = 1'b0;
              end
            end
            FN_TICK: begin
              if (pos_r == '0) begin
                aud_nxt = in_audible;
              end
              cnt_nxt   = '0;
              cl_nxt    = in_client;
              suml_nxt  = '0;
              sumr_nxt  = '0;
              state_nxt = S_SCAN;
            end
            default: begin
            end
          endcase
          if (in_func != FN_TICK) begin
            out_valid_nxt = 1'b1;
            out_q_nxt = att_vec[in_client] ? 9'(fill_nxt[in_idx]) : 9'd0;
          end
        end
      end
      S_SCAN: begin
        if (att_vec[cnt_r]) begin
          if (fill_r[cnt_r] != '0) begin
            ram_re      = 1'b1;
            ram_raddr   = AW'(cnt_r) * AW'(QUEUE_FRAMES) + AW'(rp_r[cnt_r]);
            rp_nxt[cnt_r]   = (rp_r[cnt_r] == PW'(QUEUE_FRAMES - 1)) ? '0 : rp_r[cnt_r] + 1'b1;
            fill_nxt[cnt_r] = fill_r[cnt_r] - 1'b1;
            rd_pend_nxt     = 1'b1;
          end else if (started_r[cnt_r] && aud_r) begin
            starve_nxt        = starve_r + 32'd1;
            missed_nxt[cnt_r] = 1'b1;
          end
        end
        if (cnt_r == CW'(NCE - 1)) begin
          state_nxt = S_SUM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SUM: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          if (pend) begin
            pos_nxt = '0;
            for (int c = 0; c < NCE; c++) begin
              if (att_vec[c]) begin
                if (missed_r[c] && !uflag_r[c]) begin
                  uinc = uinc + 3'd1;
                end
                uflag_nxt[c] = missed_r[c];
              end
            end
            missed_nxt = '0;
            under_nxt  = under_r + 32'(uinc);
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b0;
          out_pend_nxt  = pend;
          out_ml_nxt    = aud_r ? clamp_mix(suml_r) : 32'd0;
          out_mr_nxt    = aud_r ? clamp_mix(sumr_r) : 32'd0;
          out_q_nxt     = att_vec[cl_r] ? 9'(fill_r[cl_idx]) : 9'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int c = 0; c < NCE; c++) begin
        rp_r[c]   <= '0;
        fill_r[c] <= '0;
      end
      started_r   <= '0;
      uflag_r     <= '0;
      missed_r    <= '0;
      mask_r      <= '0;
      pos_r       <= '0;
      aud_r       <= 1'b0;
      cancel_r    <= '0;
      under_r     <= '0;
      starve_r    <= '0;
      refuse_r    <= '0;
      cnt_r       <= '0;
      cl_r        <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      started_r   <= started_nxt;
      uflag_r     <= uflag_nxt;
      missed_r    <= missed_nxt;
      mask_r      <= mask_nxt;
      pos_r       <= pos_nxt;
      aud_r       <= aud_nxt;
      cancel_r    <= cancel_nxt;
      under_r     <= under_nxt;
      starve_r    <= starve_nxt;
      refuse_r    <= refuse_nxt;
      cnt_r       <= cnt_nxt;
      cl_r        <= cl_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    suml_r     <= suml_nxt;
    sumr_r     <= sumr_nxt;
    out_acc_r  <= out_acc_nxt;
    out_pend_r <= out_pend_nxt;
    out_ml_r   <= out_ml_nxt;
    out_mr_r   <= out_mr_nxt;
    out_q_r    <= out_q_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_mix_left       = out_ml_r;
  assign out_mix_right      = out_mr_r;
  assign out_period_end     = out_pend_r;
  assign out_queued_frames  = out_q_r;
  assign out_canceled_total = cancel_r;
  assign out_underrun_total = under_r;
  assign out_starved_total  = starve_r;
  assign out_full_refusals  = refuse_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE)
    else $error("item accepted while a tick is in progress");

  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("frame memory read and write in one cycle");

  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == FN_TICK) |=> state_r == S_SCAN)
    else $error("tick did not start a scan");

  a_rd_origin: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r) == S_SCAN)
    else $error("frame data pending outside a scan");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FW'(QUEUE_FRAMES))
    else $error("queue fill beyond capacity");
endmodule

[tb/sv/amix_checker.sv]
`timescale 1ns / 1ps
module amix_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_client,
  input  logic [15:0] in_left_in,
  input  logic [15:0] in_right_in,
  input  logic        in_audible,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_accepted,
  input  logic [31:0] out_mix_left,
  input  logic [31:0] out_mix_right,
  input  logic        out_period_end,
  input  logic [8:0]  out_queued_frames,
  input  logic [31:0] out_canceled_total,
  input  logic [31:0] out_underrun_total,
  input  logic [31:0] out_starved_total,
  input  logic [31:0] out_full_refusals,
  output int          fail_count,
  output int          pending_mixes,
  output int          ticks_seen,
  output int          pushes_taken
);
  import amix_pkg::*;

  localparam int NCL   = 4;
  localparam int DEPTH = 256;
  localparam int PER   = 64;

  typedef struct packed {
    logic        accepted;
    logic [31:0] mix_l;
    logic [31:0] mix_r;
    logic        pend;
    logic [8:0]  queued;
    logic [31:0] canceled;
    logic [31:0] underruns;
    logic [31:0] starved;
    logic [31:0] refusals;
  } mix_result_t;

  logic [31:0] frames [NCL][DEPTH];
  logic [7:0]  rd_ptr [NCL];
  logic [8:0]  fill [NCL];
  logic        started [NCL];
  logic        underrun [NCL];
  logic        missed [NCL];
  logic [5:0]  pos;
  logic        loud;
  logic [31:0] n_canceled, n_underrun, n_starved, n_refused;
  logic [3:0]  mask;
  mix_result_t expected_results[$];

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic drop_client(int c);
    rd_ptr[c] = 0; fill[c] = 0; started[c] = 0; underrun[c] = 0; missed[c] = 0;
  endtask

  task automatic predict_mix(logic [1:0] fn, logic [1:0] cl, logic [15:0] l,
                             logic [15:0] r, logic aud);
    mix_result_t res;
    logic att;
    longint sl, sr;
    logic [31:0] f;
    res = '0; sl = 0; sr = 0;
    att = mask[cl];
    if (fn == FN_PUSH) begin
      if (att) begin
        if (fill[cl] < DEPTH) begin
          frames[cl][8'(rd_ptr[cl] + fill[cl])] = {r, l};
          fill[cl]++;
          started[cl] = 1;
          res.accepted = 1;
        end else n_refused++;
      end
    end else if (fn == FN_CLEAR) begin
      if (att) begin
        n_canceled += fill[cl];
        fill[cl] = 0; started[cl] = 0; underrun[cl] = 0;
      end
    end else if (fn == FN_TICK) begin
      if (pos == 0) loud = aud;
      for (int c = 0; c < NCL; c++) begin
        if (!mask[c]) continue;
        if (fill[c] > 0) begin
          f = frames[c][rd_ptr[c]];
          sl += longint'($signed(f[15:0])) * 65536;
          sr += longint'($signed(f[31:16])) * 65536;
          rd_ptr[c]++;
          fill[c]--;
        end else if (started[c] && loud) begin
          n_starved++;
          missed[c] = 1;
        end
      end
      if (loud) begin
        res.mix_l = sat32(sl);
        res.mix_r = sat32(sr);
      end
      if (pos == PER - 1) begin
        res.pend = 1;
        pos = 0;
        for (int c = 0; c < NCL; c++) begin
          if (mask[c]) begin
            if (missed[c] && !underrun[c]) n_underrun++;
            underrun[c] = missed[c];
          end
          missed[c] = 0;
        end
      end else pos++;
    end
    res.queued = att ? fill[cl] : 9'd0;
    res.canceled = n_canceled;
    res.underruns = n_underrun;
    res.starved = n_starved;
    res.refusals = n_refused;
    expected_results.push_back(res);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_mixes = expected_results.size();

  always @(posedge clk) begin
    mix_result_t e;
    if (!rst_n) begin
      for (int c = 0; c < NCL; c++) drop_client(c);
      pos = 0; loud = 0; mask = 0;
      n_canceled = 0; n_underrun = 0; n_starved = 0; n_refused = 0;
      expected_results.delete();
      fail_count = 0;
      ticks_seen <= 0; pushes_taken <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        for (int c = 0; c < NCL; c++)
          if (mask[c] && !cfg_data[c]) drop_client(c);
        mask = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (in_func == FN_TICK) ticks_seen <= ticks_seen + 1;
        predict_mix(in_func, in_client, in_left_in, in_right_in, in_audible);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (e.accepted) pushes_taken <= pushes_taken + 1;
          check_field("accepted", 32'(e.accepted), 32'(out_accepted));
          check_field("mix_left", e.mix_l, out_mix_left);
          check_field("mix_right", e.mix_r, out_mix_right);
          check_field("period_end", 32'(e.pend), 32'(out_period_end));
          check_field("queued_frames", 32'(e.queued), 32'(out_queued_frames));
          check_field("canceled_total", e.canceled, out_canceled_total);
          check_field("underrun_total", e.underruns, out_underrun_total);
          check_field("starved_total", e.starved, out_starved_total);
          check_field("full_refusals", e.refusals, out_full_refusals);
        end
      end
    end
  end

endmodule

[tb/sv/tb_multi_client_audio_fifo_mixer_top.sv]
`timescale 1ns / 1ps
module tb_multi_client_audio_fifo_mixer_top;
  import amix_pkg::*;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  in_func, in_client;
  logic [15:0] in_left_in, in_right_in;
  logic        in_audible;
  logic        out_valid, out_stall;
  logic        out_accepted, out_period_end;
  logic [31:0] out_mix_left, out_mix_right;
  logic [8:0]  out_queued_frames;
  logic [31:0] out_canceled_total, out_underrun_total, out_starved_total;
  logic [31:0] out_full_refusals;
  int          fail_count, pending_mixes, ticks_seen, pushes_taken;
  int          cycle_count;
  logic        calm;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] FN_SPARE = 2'd3;

  multi_client_audio_fifo_mixer_top uut (.*);

  amix_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side stall bursts
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // valid stays high after acceptance until the next item or an idle gap drops it
  task automatic send_item(logic [1:0] fn, logic [1:0] cl, logic [15:0] l,
                           logic [15:0] r, logic aud);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1; in_func <= fn; in_client <= cl;
    in_left_in <= l; in_right_in <= r; in_audible <= aud;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_mixes();
    in_valid <= 0;
    @(posedge clk);
    while (pending_mixes != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_mask(logic [3:0] m);
    drain_mixes();
    cfg_valid <= 1; cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic rand_sample(output logic [15:0] s);
    case ($urandom_range(0, 4))
      0: s = 16'h7fff;
      1: s = 16'h8000;
      default: s = 16'($urandom);
    endcase
  endtask

  task automatic random_phase(int count, int push_bias);
    logic [15:0] l, r;
    int k;
    for (int i = 0; i < count; i++) begin
      rand_sample(l); rand_sample(r);
      k = $urandom_range(0, 99);
      if (k < push_bias)
        send_item(FN_PUSH, 2'($urandom), l, r, $urandom_range(0, 3) != 0);
      else if (k < push_bias + 4)
        send_item(FN_CLEAR, 2'($urandom), l, r, 1'($urandom));
      else if (k < push_bias + 6)
        send_item(FN_SPARE, 2'($urandom), l, r, 1'($urandom));
      else
        send_item(FN_TICK, 2'($urandom), l, r, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    calm = 0; cycle_count = 0;
    rst_n = 0; cfg_valid = 0; cfg_data = 0; in_valid = 0;
    in_func = FN_PUSH; in_client = 0; in_left_in = 0; in_right_in = 0; in_audible = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: unattached push, then full mask with extreme samples
    send_item(FN_PUSH, 2'd0, 16'h7fff, 16'h8000, 1'b1);
    send_item(FN_TICK, 2'd0, 16'h0000, 16'h0000, 1'b1);
    write_mask(4'hf);
    for (int c = 0; c < 4; c++) send_item(FN_PUSH, 2'(c), 16'h7fff, 16'h8000, 1'b1);
    for (int c = 0; c < 4; c++) send_item(FN_PUSH, 2'(c), 16'h8000, 16'h7fff, 1'b1);
    for (int c = 0; c < 4; c++) send_item(FN_PUSH, 2'(c), 16'hffff, 16'h0001, 1'b1);
    send_item(FN_TICK, 2'd0, 16'h0000, 16'h0000, 1'b1);
    send_item(FN_TICK, 2'd1, 16'h0000, 16'h0000, 1'b1);
    send_item(FN_TICK, 2'd2, 16'h0000, 16'h0000, 1'b1);
    send_item(FN_TICK, 2'd3, 16'h0000, 16'h0000, 1'b1);
    send_item(FN_CLEAR, 2'd2, 16'h0000, 16'h0000, 1'b0);
    send_item(FN_SPARE, 2'd1, 16'h5555, 16'haaaa, 1'b1);

    // fill one queue past capacity
    write_mask(4'h1);
    for (int i = 0; i < 258; i++)
      send_item(FN_PUSH, 2'd0, 16'($urandom), 16'($urandom), 1'b1);
    send_item(FN_CLEAR, 2'd0, 16'h0000, 16'h0000, 1'b1);

    // several mask settings, random traffic
    write_mask(4'b0101);
    random_phase(60, 45);
    // hold off until the pipe is empty
    drain_mixes();
    write_mask(4'b1010);
    random_phase(60, 30);
    write_mask(4'h0);
    random_phase(20, 40);
    write_mask(4'hf);
    random_phase(60, 35);
    calm = 1;
    random_phase(40, 40);

    drain_mixes();
    $display("Covered %0d ticks and %0d stored pushes over masks 0, 1, 5, a and f.",
             ticks_seen, pushes_taken);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
